// ===== rtl/mm3_pkg.sv =====
// Package for the MurmurHash3 x86_32 stream hash unit.
// Holds item types, the queue entry type and the hash constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mm3_pkg;

    localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2 = 32'h1b873593;
    localparam logic [31:0] MM_N  = 32'he6546b64;
    localparam logic [31:0] MM_F1 = 32'h85ebca6b;
    localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

    localparam logic [2:0] FULL_WORD_BYTES = 3'd4;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_BODY,
        OP_TAIL
    } op_kind_t;

    typedef struct packed {
        logic [31:0] seed;
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        first;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] hash;
        logic        malformed;
    } out_item_t;

    typedef struct packed {
        logic [31:0] seed;
        logic [31:0] k;
        logic [2:0]  cnt;
        op_kind_t    kind;
        logic        first;
        logic        last;
    } work_t;

endpackage

`default_nettype wire

// ===== rtl/mm3_front.sv =====
// Front end: accepts input items, classifies them and scrambles the word.
// Two elastic stages, one multiplier each. Depends on mm3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mm3_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire mm3_pkg::in_item_t item_data,
    output logic                  push,
    input  wire logic             full,
    output mm3_pkg::work_t        work
);

    logic           s1_valid_reg;
    logic           s2_valid_reg;
    mm3_pkg::work_t s1_reg;
    mm3_pkg::work_t s2_reg;
    mm3_pkg::work_t s1_next;
    mm3_pkg::work_t s2_next;
    logic           s1_ready;
    logic           s2_ready;
    logic [2:0]     cnt_sat;
    logic [31:0]    mask;
    logic [31:0]    masked;
    logic [31:0]    k1_rot;

    always_comb
    begin
        cnt_sat = (item_data.byte_count > mm3_pkg::FULL_WORD_BYTES)
                  ? mm3_pkg::FULL_WORD_BYTES : item_data.byte_count;
        unique case (cnt_sat)
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'hffff_ffff;
        endcase
        s1_next       = '0;
        s1_next.seed  = item_data.seed;
        s1_next.cnt   = cnt_sat;
        s1_next.first = item_data.first;
        s1_next.last  = item_data.last;
        if ((cnt_sat == mm3_pkg::FULL_WORD_BYTES) || !item_data.last)
        begin
            s1_next.kind = mm3_pkg::OP_BODY;
        end
        else if (cnt_sat != 3'd0)
        begin
            s1_next.kind = mm3_pkg::OP_TAIL;
        end
        else
        begin
            s1_next.kind = mm3_pkg::OP_NONE;
        end
        masked    = (s1_next.kind == mm3_pkg::OP_TAIL) ? (item_data.data_word & mask)
                                                       : item_data.data_word;
        s1_next.k = masked * mm3_pkg::MM_C1;

        k1_rot    = {s1_reg.k[16:0], s1_reg.k[31:17]};
        s2_next   = s1_reg;
        s2_next.k = k1_rot * mm3_pkg::MM_C2;
    end

    assign push       = s2_valid_reg && !full;
    assign s2_ready   = !s2_valid_reg || !full;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign item_ready = s1_ready;
    assign work       = s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= item_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && item_valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mm3_fifo.sv =====
// Short queue of scrambled work items between the front and back ends.
// Register array with read and write pointers. Depends on mm3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mm3_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire mm3_pkg::work_t push_data,
    output logic                full,
    input  wire logic           pop,
    output mm3_pkg::work_t      pop_data,
    output logic                valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mm3_pkg::work_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mm3_back.sv =====
// Back end: updates the running hash, length and malformed flag per item,
// then finalizes last words through the f0, f1, f2 and out stages. Depends on mm3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mm3_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             work_valid,
    input  wire mm3_pkg::work_t   work,
    output logic                  pop,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output mm3_pkg::out_item_t    result_data
);

    logic [31:0] hash_reg;
    logic [31:0] hash_next;
    logic [31:0] len_reg;
    logic [31:0] len_next;
    logic        bad_reg;
    logic        bad_next;
    logic [31:0] h_base;
    logic [31:0] h_mix;
    logic [31:0] h_rot;

    logic        f0_valid_reg;
    logic        f1_valid_reg;
    logic        f2_valid_reg;
    logic        out_valid_reg;
    logic [31:0] f0_reg;
    logic [31:0] f1_reg;
    logic [31:0] f2_reg;
    logic        f0_bad_reg;
    logic        f1_bad_reg;
    logic        f2_bad_reg;
    mm3_pkg::out_item_t out_reg;
    logic [31:0] f0_mix;
    logic [31:0] f1_mix;
    logic        f0_ready;
    logic        f1_ready;
    logic        f2_ready;
    logic        out_ready;

    always_comb
    begin
        h_base   = work.first ? work.seed : hash_reg;
        len_next = (work.first ? 32'd0 : len_reg) + {29'd0, work.cnt};
        bad_next = (work.first ? 1'b0 : bad_reg)
                   | (!work.last && (work.cnt != mm3_pkg::FULL_WORD_BYTES));
        h_mix    = h_base ^ work.k;
        h_rot    = {h_mix[18:0], h_mix[31:19]};
        unique case (work.kind)
            mm3_pkg::OP_BODY: hash_next = (h_rot << 2) + h_rot + mm3_pkg::MM_N;
            mm3_pkg::OP_TAIL: hash_next = h_mix;
            mm3_pkg::OP_NONE: hash_next = h_base;
            default:          hash_next = h_base;
        endcase
        f0_mix = f0_reg ^ (f0_reg >> 16);
        f1_mix = f1_reg ^ (f1_reg >> 13);
    end

    assign out_ready    = !out_valid_reg || result_ready;
    assign f2_ready     = !f2_valid_reg || out_ready;
    assign f1_ready     = !f1_valid_reg || f2_ready;
    assign f0_ready     = !f0_valid_reg || f1_ready;
    assign pop          = work_valid && f0_ready;
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= '0;
            len_reg       <= '0;
            bad_reg       <= 1'b0;
            f0_valid_reg  <= 1'b0;
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                hash_reg <= hash_next;
                len_reg  <= len_next;
                bad_reg  <= bad_next;
            end
            if (f0_ready)
            begin
                f0_valid_reg <= pop && work.last;
            end
            if (f1_ready)
            begin
                f1_valid_reg <= f0_valid_reg;
            end
            if (f2_ready)
            begin
                f2_valid_reg <= f1_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= f2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && work.last)
        begin
            f0_reg     <= hash_next ^ len_next;
            f0_bad_reg <= bad_next;
        end
        if (f1_ready && f0_valid_reg)
        begin
            f1_reg     <= f0_mix * mm3_pkg::MM_F1;
            f1_bad_reg <= f0_bad_reg;
        end
        if (f2_ready && f1_valid_reg)
        begin
            f2_reg     <= f1_mix * mm3_pkg::MM_F2;
            f2_bad_reg <= f1_bad_reg;
        end
        if (out_ready && f2_valid_reg)
        begin
            out_reg.hash      <= f2_reg ^ (f2_reg >> 16);
            out_reg.malformed <= f2_bad_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/murmur3_32_stream_hash_unit.sv =====
// An item with last set passes through s1, s2, the queue, f0, f1, f2 and out to its result.
// Throughput: one word per cycle unless stalled; back end hash update is combinational.
// The front end holds one 32-bit multiplier per stage; the finalizer one each in f1 and f2.
// Reset clears the running hash, byte length and malformed flag to zero and empties
// every stage and the queue. Top level; depends on mm3_pkg, mm3_front, mm3_fifo, mm3_back.
`timescale 1ns / 1ps
`default_nettype none

module murmur3_32_stream_hash_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire mm3_pkg::in_item_t  item_data,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output mm3_pkg::out_item_t      result_data
);

    logic           fifo_push;
    logic           fifo_full;
    logic           fifo_pop;
    logic           fifo_valid;
    mm3_pkg::work_t front_work;
    mm3_pkg::work_t back_work;

    mm3_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item_data),
        .push       (fifo_push),
        .full       (fifo_full),
        .work       (front_work)
    );

    mm3_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (front_work),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .pop_data  (back_work),
        .valid     (fifo_valid)
    );

    mm3_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .work_valid   (fifo_valid),
        .work         (back_work),
        .pop          (fifo_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    assert property (@(posedge clk) disable iff (!rst_n) fifo_push |-> (!fifo_full || fifo_pop))
        else $error("Queue written while full.");

    assert property (@(posedge clk) disable iff (!rst_n) fifo_pop |-> fifo_valid)
        else $error("Queue read while empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_full && !fifo_pop) |=> !fifo_push || fifo_pop)
        else $error("Front end pushed into a full queue.");

endmodule

`default_nettype wire

// ===== dv/murmur3_32_hash_checker.sv =====
// Checker for the MurmurHash3 x86_32 stream hash unit: watches both channels, keeps its
// own running hash per accepted item and compares each result in order.
// Depends on mm3_pkg for the item types and hash constants.
`timescale 1ns / 1ps

module murmur3_32_hash_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  wire logic               item_ready,
    input  wire mm3_pkg::in_item_t  item_data,
    input  wire logic               result_valid,
    input  wire logic               result_ready,
    input  wire mm3_pkg::out_item_t result_data,
    output int                      mismatches,
    output int                      outstanding,
    output int                      hashes_checked,
    output int                      malformed_seen
);
    import mm3_pkg::*;

    logic [31:0] run_hash = '0;
    logic [31:0] msg_bytes = '0;
    logic        short_word_seen = 1'b0;
    out_item_t   expected_hashes[$];
    int          n_err = 0;
    int          n_hash = 0;
    int          n_mal = 0;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [31:0] scramble_k(input logic [31:0] k);
        logic [31:0] t;
        t = k * MM_C1;
        t = rotl32(t, 15);
        t = t * MM_C2;
        return t;
    endfunction

    function automatic logic [31:0] fmix32(input logic [31:0] h, input logic [31:0] len);
        logic [31:0] t;
        t = h ^ len;
        t = t ^ (t >> 16);
        t = t * MM_F1;
        t = t ^ (t >> 13);
        t = t * MM_F2;
        t = t ^ (t >> 16);
        return t;
    endfunction

    task automatic absorb_word(input in_item_t w);
        logic [2:0]  n;
        int          nb;
        logic [31:0] mask;
        out_item_t   e;
        n = (w.byte_count > FULL_WORD_BYTES) ? FULL_WORD_BYTES : w.byte_count;
        nb = int'(n);
        if (w.first)
        begin
            run_hash = w.seed;
            msg_bytes = '0;
            short_word_seen = 1'b0;
        end
        if (n == FULL_WORD_BYTES || !w.last)
        begin
            run_hash = run_hash ^ scramble_k(w.data_word);
            run_hash = rotl32(run_hash, 13);
            run_hash = run_hash * 32'd5 + MM_N;
            if (n != FULL_WORD_BYTES)
                short_word_seen = 1'b1;
        end
        else if (nb != 0)
        begin
            mask = 32'hffffffff >> (32 - 8 * nb);
            run_hash = run_hash ^ scramble_k(w.data_word & mask);
        end
        msg_bytes = msg_bytes + 32'(nb);
        if (w.last)
        begin
            e.hash = fmix32(run_hash, msg_bytes);
            e.malformed = short_word_seen;
            expected_hashes.push_back(e);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s, got %h, expected %h", $realtime, what, got, want);
        n_err++;
    endtask

    always @(posedge clk)
    begin : watch
        out_item_t want;
        if (rst_n)
        begin
            if (item_valid && item_ready)
                absorb_word(item_data);
            if (result_valid && result_ready)
            begin
                if (expected_hashes.size() == 0)
                    report_mismatch("result with no message pending", result_data.hash, '0);
                else
                begin
                    want = expected_hashes.pop_front();
                    if (result_data.hash !== want.hash)
                        report_mismatch("hash", result_data.hash, want.hash);
                    if (result_data.malformed !== want.malformed)
                        report_mismatch("malformed", 32'(result_data.malformed),
                                        32'(want.malformed));
                    n_hash++;
                    if (want.malformed)
                        n_mal++;
                end
            end
        end
        mismatches <= n_err;
        outstanding <= expected_hashes.size();
        hashes_checked <= n_hash;
        malformed_seen <= n_mal;
    end

endmodule

// ===== dv/murmur3_32_stream_hash_unit_test.sv =====
// Top of the testbench for the MurmurHash3 x86_32 stream hash unit: clock, reset,
// directed and random message stimulus, result backpressure and the verdict.
// Depends on mm3_pkg, murmur3_32_stream_hash_unit and murmur3_32_hash_checker.
`timescale 1ns / 1ps

module murmur3_32_stream_hash_unit_test;
    import mm3_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_ready;
    in_item_t  item_data = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result_data;

    int        mismatches;
    int        outstanding;
    int        hashes_checked;
    int        malformed_seen;
    int        items_sent = 0;
    bit        calm = 1'b0;

    always #5 clk = ~clk;

    murmur3_32_stream_hash_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    murmur3_32_hash_checker hash_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item_data      (item_data),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result_data    (result_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .hashes_checked (hashes_checked),
        .malformed_seen (malformed_seen)
    );

    task automatic send_word(input logic [31:0] seed, input logic [31:0] word,
                             input logic [2:0] cnt, input logic first, input logic last);
        in_item_t w;
        w.seed = seed;
        w.data_word = word;
        w.byte_count = cnt;
        w.first = first;
        w.last = last;
        while (!calm && $urandom_range(99) < 31)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data <= w;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        forever
        begin
            @(posedge clk);
            result_ready <= calm || ($urandom_range(99) >= 31);
        end
    end

    initial
    begin
        int          msg_no;
        int          pick;
        int          n_body;
        int          j;
        logic [31:0] seed;
        logic [2:0]  tail;
        logic [2:0]  cnt;
        logic        fst;
        logic        lst;
        logic        broken;

        repeat (2) @(posedge clk);

        // Words with no first after reset continue from a zero seed.
        send_word(32'h0, 32'hffffffff, 3'd4, 1'b0, 1'b0);
        send_word(32'hffffffff, 32'h0, 3'd0, 1'b0, 1'b1);
        send_word(32'h0, 32'h0, 3'd0, 1'b1, 1'b1);
        send_word(32'hffffffff, 32'hffffffff, 3'd0, 1'b1, 1'b1);
        send_word(32'h0, 32'hffffffff, 3'd1, 1'b1, 1'b1);
        send_word(32'h0, 32'ha5a5a5a5, 3'd2, 1'b1, 1'b1);
        send_word(32'h5a5a5a5a, 32'h5a5a5a5a, 3'd3, 1'b1, 1'b1);
        send_word(32'hffffffff, 32'hffffffff, 3'd4, 1'b1, 1'b1);
        send_word(32'h1, 32'h80000001, 3'd5, 1'b1, 1'b1);
        send_word(32'h80000000, 32'h7fffffff, 3'd6, 1'b1, 1'b1);
        send_word(32'hdeadbeef, 32'h01234567, 3'd7, 1'b1, 1'b1);
        // A short word inside a message marks it malformed.
        send_word(32'h12345678, 32'h0, 3'd4, 1'b1, 1'b0);
        send_word(32'h0, 32'hcafef00d, 3'd2, 1'b0, 1'b0);
        send_word(32'h0, 32'h89abcdef, 3'd3, 1'b0, 1'b1);
        // Continuing after a last word carries the old state on.
        send_word(32'h0, 32'h13579bdf, 3'd4, 1'b0, 1'b1);
        send_word(32'h0f0f0f0f, 32'hf0f0f0f0, 3'd7, 1'b1, 1'b0);
        send_word(32'h0, 32'h0, 3'd0, 1'b0, 1'b0);
        send_word(32'h0, 32'hffffffff, 3'd1, 1'b0, 1'b1);
        // A new first in mid message restarts it and clears the malformed flag.
        send_word(32'h2468ace0, 32'h11111111, 3'd1, 1'b1, 1'b0);
        send_word(32'h3c3c3c3c, 32'h22222222, 3'd2, 1'b1, 1'b1);

        msg_no = 0;
        while (items_sent < 1170)
        begin
            msg_no++;
            calm = (msg_no >= 120 && msg_no < 170);
            pick = $urandom_range(99);
            if (pick < 6)
                send_word($urandom(), $urandom(), 3'($urandom_range(7)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            else
            begin
                case ($urandom_range(7))
                    0: seed = 32'h0;
                    1: seed = 32'hffffffff;
                    default: seed = $urandom();
                endcase
                n_body = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(5);
                tail = 3'($urandom_range(4));
                broken = (pick < 18);
                for (j = 0; j <= n_body; j++)
                begin
                    fst = (j == 0);
                    lst = (j == n_body);
                    cnt = lst ? tail : FULL_WORD_BYTES;
                    if (broken)
                    begin
                        if ($urandom_range(3) == 0)
                            cnt = 3'($urandom_range(7));
                        if (fst && $urandom_range(1))
                            fst = 1'b0;
                    end
                    send_word(seed, $urandom(), cnt, fst, lst);
                end
            end
        end
        calm = 1'b0;
        item_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("summary: %0d words sent, %0d hashes checked, %0d of them malformed",
                 items_sent, hashes_checked, malformed_seen);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d hashes still pending", outstanding);
        $display("tb: failure");
        $finish;
    end

endmodule
